FILE: hdl/pidfd_pkg.sv
// ----------------------------------------------------------------------------
// pidfd_pkg
// Shared constants and types of the filtered-derivative PID block: digit size
// of the serial multiplier, term limits and configuration register indexes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pidfd_pkg;

    // Multiplier digit: bits of the second operand consumed per cycle.
    localparam int DIGIT_W = 8;

    // Derivative filter coefficient, unsigned Q0.16.
    localparam int POLE_W = 16;

    // Every product term is clipped to +-(2^61 - 1), which fits 62 signed bits.
    localparam int TERM_W = 62;
    localparam logic signed [TERM_W-1:0] TERM_LIM = {1'b0, {(TERM_W-1){1'b1}}};

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 3;
    typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

    localparam cfg_addr_t CFG_GAIN_P    = 3'd0;
    localparam cfg_addr_t CFG_GAIN_I    = 3'd1;
    localparam cfg_addr_t CFG_GAIN_D    = 3'd2;
    localparam cfg_addr_t CFG_GAIN_FF   = 3'd3;
    localparam cfg_addr_t CFG_POLE      = 3'd4;
    localparam cfg_addr_t CFG_OVR_EN    = 3'd5;
    localparam cfg_addr_t CFG_OVR_VALUE = 3'd6;

endpackage

FILE: hdl/pidfd_dmul.sv
// ----------------------------------------------------------------------------
// pidfd_dmul
// Digit-serial signed multiplier. Takes one digit of the second operand per
// cycle, least significant first; the top digit carries the sign.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pidfd_dmul #(
    parameter int A_W  = 48,
    parameter int NDIG = 4
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          start,
    input  logic signed [A_W-1:0]                         a_in,
    input  logic [NDIG*pidfd_pkg::DIGIT_W-1:0]            b_in,
    output logic                                          last,
    output logic signed [A_W+NDIG*pidfd_pkg::DIGIT_W:0]   prod
);

    localparam int DW    = pidfd_pkg::DIGIT_W;
    localparam int B_W   = NDIG * DW;
    localparam int S_W   = A_W + DW + 2;
    localparam int CNT_W = $clog2(NDIG + 1);

    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic signed [A_W-1:0]  a_reg, a_next;
    logic [B_W-1:0]         b_reg, b_next;
    logic signed [A_W:0]    hi_reg, hi_next;
    logic [B_W-1:0]         lo_reg, lo_next;

    logic signed [DW:0]     dig;
    logic signed [A_W+DW:0] pp;
    logic signed [S_W-1:0]  sum;

    // Low digits are unsigned, the final one is two's complement.
    assign dig  = (cnt_reg == CNT_W'(1)) ? {b_reg[DW-1], b_reg[DW-1:0]}
                                         : {1'b0, b_reg[DW-1:0]};
    assign pp   = a_reg * dig;
    assign sum  = S_W'(hi_reg) + S_W'(pp);
    assign last = (cnt_reg == CNT_W'(1));
    assign prod = {hi_reg, lo_reg};

    always_comb begin
        cnt_next = cnt_reg;
        a_next   = a_reg;
        b_next   = b_reg;
        hi_next  = hi_reg;
        lo_next  = lo_reg;
        if (start) begin
            cnt_next = CNT_W'(NDIG);
            a_next   = a_in;
            b_next   = b_in;
            hi_next  = '0;
            lo_next  = '0;
        end else if (cnt_reg != '0) begin
            // shift the finished digit of the product into the low word
            cnt_next = cnt_reg - CNT_W'(1);
            b_next   = b_reg >> DW;
            hi_next  = sum[DW +: A_W+1];
            lo_next  = B_W'({sum[DW-1:0], lo_reg} >> DW);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg  <= a_next;
        b_reg  <= b_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

endmodule

FILE: hdl/pid_filtered_derivative.sv
// ----------------------------------------------------------------------------
// pid_filtered_derivative
// Fixed-point PID controller with a low-pass filtered derivative and a
// feedforward term; drive is signed Q(DATA_WIDTH-FRAC_BITS).FRAC_BITS.
//
// Input beats arrive on s_t*: s_tuser is the kind (0: setpoint and measured,
// 1: ready-made error), s_tdata holds setpoint, measured and error_in.
// One result beat per input beat leaves on m_t*: m_tdata holds drive, m_tuser
// the saturated flag. Gains, filter pole and setpoint override are to be written
// through cfg_we / cfg_addr / cfg_wdata while the block is idle (not enforced).
//
// All products go through one digit-serial multiplier that takes 8 bits of
// the gain (or of 1 - r) per cycle; each product passes a load, a multiply
// over NDIG digits (NDIG = 4 at the default width), a clip and an accumulate
// step. A kind 0 beat needs five products, a kind 1 beat four; a new beat
// is taken only once the last result has gone into the output register.
//
// Reset clears the configuration, sequencer and controller state (error
// sum, filtered derivative, previous error). When the receiver stalls the
// result holds in the output register; the next beat is still taken and
// worked off, then waits for a free output register with s_tready low.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pid_filtered_derivative #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16,
    parameter int ACC_WIDTH  = 48
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,

    // configuration write port
    input  logic                                   cfg_we,
    input  logic [pidfd_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [DATA_WIDTH-1:0]                  cfg_wdata,

    // input beats
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // tdata: setpoint, measured, error_in (lowest first), zero padded
    input  logic [((3*DATA_WIDTH+7)/8)*8-1:0]      s_tdata,
    // tuser: kind
    input  logic                                   s_tuser,

    // result beats
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // tdata: drive, zero padded
    output logic [((DATA_WIDTH+7)/8)*8-1:0]        m_tdata,
    // tuser: saturated
    output logic                                   m_tuser
);

    localparam int DW     = DATA_WIDTH;
    localparam int AW     = ACC_WIDTH;
    localparam int XW     = DW + 2;
    localparam int MA_W   = (AW > XW) ? AW : XW;
    localparam int MB_W   = (DW > pidfd_pkg::POLE_W + 2) ? DW : pidfd_pkg::POLE_W + 2;
    localparam int NDIG   = (MB_W + pidfd_pkg::DIGIT_W - 1) / pidfd_pkg::DIGIT_W;
    localparam int MB_PAD = NDIG * pidfd_pkg::DIGIT_W;
    localparam int PW     = MA_W + 1 + MB_PAD;
    localparam int TW     = pidfd_pkg::TERM_W;
    localparam int CW     = (PW > TW + 1) ? PW : TW + 1;
    localparam int ESW    = ((AW > DW) ? AW : DW) + 1;
    localparam int DSW    = TW + 1;
    localparam int TOT_W  = TW + 2;
    localparam int OUT_W  = ((DW + 7) / 8) * 8;
    localparam bit SUM_FLAG = (ACC_WIDTH < 64);

    localparam logic signed [DW-1:0] D_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] D_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [AW-1:0] A_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] A_MIN = {1'b1, {(AW-1){1'b0}}};

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_ERR  = 7'b0000010,
        S_LOAD = 7'b0000100,
        S_MUL  = 7'b0001000,
        S_TERM = 7'b0010000,
        S_ACC  = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    // product being formed
    typedef enum logic [2:0] {
        OP_DER = 3'd0,
        OP_P   = 3'd1,
        OP_I   = 3'd2,
        OP_D   = 3'd3,
        OP_FF  = 3'd4
    } op_t;

    // configuration registers
    logic signed [DW-1:0]             gain_p_reg, gain_i_reg, gain_d_reg, gain_ff_reg;
    logic [pidfd_pkg::POLE_W-1:0]     pole_reg;
    logic                             ovr_en_reg;
    logic signed [DW-1:0]             ovr_val_reg;

    // controller state
    logic signed [AW-1:0]             et_reg, et_next;
    logic signed [DW-1:0]             d_reg, d_next;
    logic signed [DW-1:0]             prev_reg, prev_next;

    // control
    state_t                           state_reg, state_next;
    op_t                              op_reg, op_next;
    logic                             m_tvalid_reg, m_tvalid_next;

    // per-beat working registers
    logic                             kind_reg, kind_next;
    logic signed [DW-1:0]             sp_reg, sp_next;
    logic signed [DW-1:0]             e_reg, e_next;
    logic signed [XW-1:0]             x_reg, x_next;
    logic signed [TW-1:0]             term_reg, term_next;
    logic signed [TOT_W-1:0]          tot_reg, tot_next;
    logic                             clip_reg, clip_next;
    logic signed [DW-1:0]             m_drive_reg, m_drive_next;
    logic                             m_sat_reg, m_sat_next;

    // multiplier hookup
    logic                             mul_start;
    logic                             mul_last;
    logic signed [MA_W-1:0]           mul_a;
    logic [MB_PAD-1:0]                mul_b;
    logic signed [PW-1:0]             mul_prod;

    // datapath
    logic signed [DW-1:0]             sp_sel, meas_in, err_direct, e_clamped, e_in;
    logic signed [DW:0]               e_diff;
    logic                             e_ovf;
    logic signed [ESW-1:0]            et_sum;
    logic                             et_ovf;
    logic signed [AW-1:0]             et_sat;
    logic signed [XW-1:0]             x_val;
    logic [pidfd_pkg::POLE_W:0]       one_minus_r;
    logic signed [CW-1:0]             q_full, q_shift, lim_pos, lim_neg;
    logic                             term_hi, term_lo;
    logic signed [TW-1:0]             term_clamped;
    logic signed [DSW-1:0]            d_sum;
    logic                             d_ovf;
    logic signed [DW-1:0]             d_sat;
    logic signed [TOT_W-1:0]          tot_sum;
    logic                             drive_ovf;
    logic signed [DW-1:0]             drive_sat;

    // ------------------------------------------------------------------
    // Configuration writes; unknown indexes drop the write.
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_p_reg  <= '0;
            gain_i_reg  <= '0;
            gain_d_reg  <= '0;
            gain_ff_reg <= '0;
            pole_reg    <= '0;
            ovr_en_reg  <= 1'b0;
            ovr_val_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                pidfd_pkg::CFG_GAIN_P:    gain_p_reg  <= cfg_wdata;
                pidfd_pkg::CFG_GAIN_I:    gain_i_reg  <= cfg_wdata;
                pidfd_pkg::CFG_GAIN_D:    gain_d_reg  <= cfg_wdata;
                pidfd_pkg::CFG_GAIN_FF:   gain_ff_reg <= cfg_wdata;
                pidfd_pkg::CFG_POLE:      pole_reg    <= cfg_wdata[pidfd_pkg::POLE_W-1:0];
                pidfd_pkg::CFG_OVR_EN:    ovr_en_reg  <= cfg_wdata[0];
                pidfd_pkg::CFG_OVR_VALUE: ovr_val_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Error of the incoming beat: setpoint (or override) minus measured,
    // saturated to the data width, or the error given directly.
    // ------------------------------------------------------------------
    assign meas_in    = s_tdata[2*DW-1:DW];
    assign err_direct = s_tdata[3*DW-1:2*DW];
    assign sp_sel     = ovr_en_reg ? ovr_val_reg : s_tdata[DW-1:0];
    assign e_diff     = (DW+1)'(sp_sel) - (DW+1)'(meas_in);
    assign e_ovf      = e_diff[DW] ^ e_diff[DW-1];
    assign e_clamped  = e_ovf ? (e_diff[DW] ? D_MIN : D_MAX) : e_diff[DW-1:0];
    assign e_in       = s_tuser ? err_direct : e_clamped;

    // Error sum, saturated to the accumulator width.
    assign et_sum = ESW'(et_reg) + ESW'(e_reg);
    assign et_ovf = !((&et_sum[ESW-1:AW-1]) || (~|et_sum[ESW-1:AW-1]));
    assign et_sat = et_ovf ? (et_sum[ESW-1] ? A_MIN : A_MAX) : et_sum[AW-1:0];

    // Input of the derivative filter step: (e - e_prev) - d.
    assign x_val = XW'(e_reg) - XW'(prev_reg) - XW'(d_reg);

    // 1 - r in unsigned Q1.16, from 1/65536 up to exactly one.
    assign one_minus_r = {1'b1, {pidfd_pkg::POLE_W{1'b0}}} - {1'b0, pole_reg};

    // ------------------------------------------------------------------
    // Operand select for the shared multiplier.
    // ------------------------------------------------------------------
    always_comb begin
        unique case (op_reg)
            OP_DER: begin
                mul_a = MA_W'(x_reg);
                mul_b = MB_PAD'(one_minus_r);
            end
            OP_P: begin
                mul_a = MA_W'(e_reg);
                mul_b = MB_PAD'(gain_p_reg);
            end
            OP_I: begin
                mul_a = MA_W'(et_reg);
                mul_b = MB_PAD'(gain_i_reg);
            end
            OP_D: begin
                mul_a = MA_W'(d_reg);
                mul_b = MB_PAD'(gain_d_reg);
            end
            OP_FF: begin
                mul_a = MA_W'(sp_reg);
                mul_b = MB_PAD'(gain_ff_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    pidfd_dmul #(
        .A_W  (MA_W),
        .NDIG (NDIG)
    ) u_dmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .last    (mul_last),
        .prod    (mul_prod)
    );

    // ------------------------------------------------------------------
    // Scale the exact product back (arithmetic shift rounds toward minus
    // infinity) and clip it to the term limit.
    // ------------------------------------------------------------------
    assign q_full       = CW'(mul_prod);
    assign q_shift      = (op_reg == OP_DER) ? (q_full >>> pidfd_pkg::POLE_W)
                                             : (q_full >>> FRAC_BITS);
    assign lim_pos      = CW'(pidfd_pkg::TERM_LIM);
    assign lim_neg      = -lim_pos;
    assign term_hi      = (q_shift > lim_pos);
    assign term_lo      = (q_shift < lim_neg);
    assign term_clamped = term_hi ? pidfd_pkg::TERM_LIM
                        : term_lo ? -pidfd_pkg::TERM_LIM
                        : q_shift[TW-1:0];

    // Filtered derivative update, saturated to the data width.
    assign d_sum = DSW'(d_reg) + DSW'(term_reg);
    assign d_ovf = !((&d_sum[DSW-1:DW-1]) || (~|d_sum[DSW-1:DW-1]));
    assign d_sat = d_ovf ? (d_sum[DSW-1] ? D_MIN : D_MAX) : d_sum[DW-1:0];

    // Running sum of the terms and the final drive clamp.
    assign tot_sum   = tot_reg + TOT_W'(term_reg);
    assign drive_ovf = !((&tot_reg[TOT_W-1:DW-1]) || (~|tot_reg[TOT_W-1:DW-1]));
    assign drive_sat = drive_ovf ? (tot_reg[TOT_W-1] ? D_MIN : D_MAX) : tot_reg[DW-1:0];

    // ------------------------------------------------------------------
    // Sequencer: error, then derivative, P, I, D and (kind 0) feedforward
    // products, each followed by a clip and an accumulate step.
    // ------------------------------------------------------------------
    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        kind_next     = kind_reg;
        sp_next       = sp_reg;
        e_next        = e_reg;
        x_next        = x_reg;
        term_next     = term_reg;
        tot_next      = tot_reg;
        clip_next     = clip_reg;
        et_next       = et_reg;
        d_next        = d_reg;
        prev_next     = prev_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        m_drive_next  = m_drive_reg;
        m_sat_next    = m_sat_reg;
        mul_start     = 1'b0;

        unique case (state_reg)
            S_IDLE: begin
                // take the beat, latch setpoint and error
                if (s_tvalid) begin
                    kind_next  = s_tuser;
                    sp_next    = sp_sel;
                    e_next     = e_in;
                    clip_next  = 1'b0;
                    state_next = S_ERR;
                end
            end
            S_ERR: begin
                et_next = et_sat;
                if (et_ovf && SUM_FLAG) begin
                    clip_next = 1'b1;
                end
                x_next     = x_val;
                prev_next  = e_reg;
                // with a direct error the feedforward gain is a plain offset
                tot_next   = kind_reg ? TOT_W'(gain_ff_reg) : '0;
                op_next    = OP_DER;
                state_next = S_LOAD;
            end
            S_LOAD: begin
                mul_start  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL: begin
                if (mul_last) begin
                    state_next = S_TERM;
                end
            end
            S_TERM: begin
                term_next = term_clamped;
                // a clipped filter step is silent
                if ((term_hi || term_lo) && (op_reg != OP_DER)) begin
                    clip_next = 1'b1;
                end
                state_next = S_ACC;
            end
            S_ACC: begin
                state_next = S_LOAD;
                unique case (op_reg)
                    OP_DER: begin
                        d_next  = d_sat;
                        op_next = OP_P;
                    end
                    OP_P: begin
                        tot_next = tot_sum;
                        op_next  = OP_I;
                    end
                    OP_I: begin
                        tot_next = tot_sum;
                        op_next  = OP_D;
                    end
                    OP_D: begin
                        tot_next = tot_sum;
                        if (kind_reg) begin
                            state_next = S_OUT;
                        end else begin
                            op_next = OP_FF;
                        end
                    end
                    OP_FF: begin
                        tot_next   = tot_sum;
                        state_next = S_OUT;
                    end
                    default: begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_OUT: begin
                // hold until the output register is free or being drained
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_drive_next  = drive_sat;
                    m_sat_next    = clip_reg | drive_ovf;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            op_reg       <= OP_DER;
            m_tvalid_reg <= 1'b0;
            et_reg       <= '0;
            d_reg        <= '0;
            prev_reg     <= '0;
        end else begin
            state_reg    <= state_next;
            op_reg       <= op_next;
            m_tvalid_reg <= m_tvalid_next;
            et_reg       <= et_next;
            d_reg        <= d_next;
            prev_reg     <= prev_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        sp_reg      <= sp_next;
        e_reg       <= e_next;
        x_reg       <= x_next;
        term_reg    <= term_next;
        tot_reg     <= tot_next;
        clip_reg    <= clip_next;
        m_drive_reg <= m_drive_next;
        m_sat_reg   <= m_sat_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_W'($unsigned(m_drive_reg));
    assign m_tuser  = m_sat_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_mul_done_in_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_last |-> (state_reg == S_MUL))
        else $error("multiplier finished outside the multiply step");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg == S_OUT))
        else $error("result beat raised outside the output step");

    a_term_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ACC) |-> ((term_reg <= pidfd_pkg::TERM_LIM) &&
                                  (term_reg >= -pidfd_pkg::TERM_LIM)))
        else $error("product term beyond the clip limit");

endmodule
